// ===== rtl/selection_sorter_defines.svh =====
// Assertion macros for the selection sorter.
// Each macro takes a label, the clock, the reset and the expression to check.
`ifndef SELECTION_SORTER_DEFINES_SVH
`define SELECTION_SORTER_DEFINES_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define SS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("selection_sorter: assertion failed")

// The condition must never be true outside reset.
`define SS_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("selection_sorter: forbidden condition seen")

`else

`define SS_ASSERT(label, clk, rst, prop)
`define SS_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ===== rtl/ss_pkg.sv =====
`timescale 1ns / 1ps

package ss_pkg;

  // Store depth and the widths that follow from it.
  localparam int MAX_ELEMENTS = 64;
  localparam int DATA_W       = 32;
  localparam int AW           = (MAX_ELEMENTS > 2) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW           = $clog2(MAX_ELEMENTS + 1);

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [AW-1:0]     addr_t;
  typedef logic [CW-1:0]     count_t;

  // Commands from the sequencer to the minimum tracker.
  typedef struct packed {
    logic load;  // take the candidate as the new running minimum
    logic step;  // compare the candidate and keep the smaller one
  } min_ctl_t;

endpackage

// ===== rtl/selection_sorter.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Width  Contents
// s_*      in   32     tdata = value; tlast = last_in
// m_*      out  32     tdata = sorted_value; tlast = last_out; tuser = overflow
//
// Loading takes one word per cycle. After the last word the set of n elements is
// sorted in place; each pass is paced by the single read port of the store and
// the single comparator. Each sorted word is then read from the store, registered
// onto m_tdata and held until m_tready is high. Reset is synchronous; s_tready is
// high only while loading.
`include "selection_sorter_defines.svh"

module selection_sorter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] sorted_value
  output logic        m_tlast,
  output logic        m_tuser    // [0] overflow
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_HEAD,
    S_LOADMIN,
    S_SCAN,
    S_SWAP1,
    S_SWAP2,
    S_EREAD,
    S_ELOAD,
    S_EHOLD
  } state_t;

  state_t           state;
  ss_pkg::count_t   count;
  logic             ovf;
  ss_pkg::addr_t    i_idx;
  ss_pkg::addr_t    j_idx;
  ss_pkg::addr_t    k_idx;
  ss_pkg::word_t    head;

  ss_pkg::count_t   n_m1;
  ss_pkg::addr_t    last_idx;
  logic             has_room;
  ss_pkg::count_t   count_next;

  logic             mem_we;
  ss_pkg::addr_t    mem_waddr;
  ss_pkg::word_t    mem_wdata;
  ss_pkg::addr_t    mem_raddr;
  ss_pkg::word_t    mem_rdata;

  ss_pkg::min_ctl_t min_ctl;
  ss_pkg::addr_t    cand_idx;
  ss_pkg::word_t    min_val;
  ss_pkg::addr_t    min_idx;

  ss_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ss_min_unit u_min (
    .clk      (clk),
    .ctl      (min_ctl),
    .cand_val (mem_rdata),
    .cand_idx (cand_idx),
    .min_val  (min_val),
    .min_idx  (min_idx)
  );

  // Index of the last stored element and room left in the store.
  assign n_m1       = count - ss_pkg::CW'(1);
  assign last_idx   = n_m1[ss_pkg::AW-1:0];
  assign has_room   = count < ss_pkg::CW'(ss_pkg::MAX_ELEMENTS);
  assign count_next = has_room ? count + ss_pkg::CW'(1) : count;
  assign s_tready   = (state == S_LOAD);

  // Store ports and comparator commands for each step of the sequencer.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = i_idx;
    mem_wdata = min_val;
    mem_raddr = i_idx;
    min_ctl   = '0;
    cand_idx  = j_idx;
    unique case (state)
      S_LOAD: begin
        mem_we    = s_tvalid && has_room;
        mem_waddr = count[ss_pkg::AW-1:0];
        mem_wdata = s_tdata;
      end
      S_HEAD: begin
        mem_raddr = i_idx;
      end
      S_LOADMIN: begin
        mem_raddr    = i_idx + ss_pkg::AW'(1);
        min_ctl.load = 1'b1;
        cand_idx     = i_idx;
      end
      S_SCAN: begin
        mem_raddr    = (j_idx == last_idx) ? j_idx : j_idx + ss_pkg::AW'(1);
        min_ctl.step = 1'b1;
        cand_idx     = j_idx;
      end
      S_SWAP1: begin
        mem_we    = 1'b1;
        mem_waddr = i_idx;
        mem_wdata = min_val;
      end
      S_SWAP2: begin
        mem_we    = 1'b1;
        mem_waddr = min_idx;
        mem_wdata = head;
      end
      S_EREAD, S_ELOAD, S_EHOLD: begin
        mem_raddr = k_idx;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequencer: load, sort passes, then read out the sorted run.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      count    <= '0;
      ovf      <= 1'b0;
      i_idx    <= '0;
      j_idx    <= '0;
      k_idx    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (s_tvalid) begin
            count <= count_next;
            if (!has_room) begin
              ovf <= 1'b1;
            end
            if (s_tlast) begin
              i_idx <= '0;
              k_idx <= '0;
              state <= (count_next == ss_pkg::CW'(1)) ? S_EREAD : S_HEAD;
            end
          end
        end
        S_HEAD: begin
          state <= S_LOADMIN;
        end
        S_LOADMIN: begin
          head  <= mem_rdata;
          j_idx <= i_idx + ss_pkg::AW'(1);
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (j_idx == last_idx) begin
            state <= S_SWAP1;
          end else begin
            j_idx <= j_idx + ss_pkg::AW'(1);
          end
        end
        S_SWAP1: begin
          state <= S_SWAP2;
        end
        S_SWAP2: begin
          if ((ss_pkg::CW'(i_idx) + ss_pkg::CW'(1)) == n_m1) begin
            k_idx <= '0;
            state <= S_EREAD;
          end else begin
            i_idx <= i_idx + ss_pkg::AW'(1);
            state <= S_HEAD;
          end
        end
        S_EREAD: begin
          state <= S_ELOAD;
        end
        S_ELOAD: begin
          m_tvalid <= 1'b1;
          m_tdata  <= mem_rdata;
          m_tlast  <= (k_idx == last_idx);
          m_tuser  <= ovf;
          state    <= S_EHOLD;
        end
        S_EHOLD: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (m_tlast) begin
              count <= '0;
              ovf   <= 1'b0;
              state <= S_LOAD;
            end else begin
              k_idx <= k_idx + ss_pkg::AW'(1);
              state <= S_EREAD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // Loading and read-out never overlap.
  `SS_ASSERT_NEVER(a_no_overlap, clk, rst, s_tready && m_tvalid);

  // The fill count never passes the store depth.
  `SS_ASSERT(a_count_range, clk, rst, count <= ss_pkg::CW'(ss_pkg::MAX_ELEMENTS));

  // The scan pointer stays inside the stored set.
  `SS_ASSERT(a_scan_range, clk, rst, (state == S_SCAN) |-> (j_idx <= last_idx));

  // After the final word of a run the block is empty and loading again.
  `SS_ASSERT(a_run_end, clk, rst,
    (m_tvalid && m_tready && m_tlast) |=> (s_tready && (count == '0) && !ovf));

endmodule

// ===== rtl/ss_ram.sv =====
`timescale 1ns / 1ps

// Element store: one write port, one read port with registered read data.
module ss_ram (
  input  logic          clk,
  input  logic          we,
  input  ss_pkg::addr_t waddr,
  input  ss_pkg::word_t wdata,
  input  ss_pkg::addr_t raddr,
  output ss_pkg::word_t rdata
);

  ss_pkg::word_t mem [ss_pkg::MAX_ELEMENTS];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ss_min_unit.sv =====
`timescale 1ns / 1ps

// Running minimum tracker: the one signed comparator of the block.
module ss_min_unit (
  input  logic             clk,
  input  ss_pkg::min_ctl_t ctl,
  input  ss_pkg::word_t    cand_val,
  input  ss_pkg::addr_t    cand_idx,
  output ss_pkg::word_t    min_val,
  output ss_pkg::addr_t    min_idx
);

  logic cand_less;

  // Signed compare of the candidate against the held minimum.
  assign cand_less = $signed(cand_val) < $signed(min_val);

  // Load a new minimum at the start of a pass, or keep the smaller value.
  always_ff @(posedge clk) begin
    if (ctl.load || (ctl.step && cand_less)) begin
      min_val <= cand_val;
      min_idx <= cand_idx;
    end
  end

endmodule
